@@ design/rrss_pkg.sv @@
// Shared types and constants of the resultant rhythm step sequencer.
package rrss_pkg;

   localparam int LevelWidth   = 16;
   localparam int JumpWidth    = 16;
   localparam int CntWidth     = 12;
   localparam int GenWidth     = 6;
   localparam int DvdWidth     = 16;
   localparam int IterWidth    = $clog2(DvdWidth);
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 6;
   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 80;

   localparam logic [IterWidth-1:0] IterLast = IterWidth'(DvdWidth - 1);
   localparam logic [CntWidth-1:0]  CntMax   = {CntWidth{1'b1}};

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_PATTERN = 2'd0,
      CSR_GEN_A   = 2'd1,
      CSR_GEN_B   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MOD_STEPS = 2'd0,
      MOD_PER_A = 2'd1,
      MOD_PER_B = 2'd2
   } mod_src_type;

   typedef struct packed {
      logic        capture;
      logic        start;
      mod_src_type sel;
      logic        step;
      logic        save_cnt;
      logic        save_a;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic mod_done;
   } dp_status_type;

endpackage

@@ design/resultant_rhythm_step_sequencer_unit.sv @@
// Top level of the resultant rhythm step sequencer.
// Each req transaction runs three modulo passes before its result reaches rsp_tvalid.
// A new item is taken only once the last is done: one shared bit-serial modulo unit.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high) clears the step counter, the previous jump,
// the configuration registers and the handshake state.
module resultant_rhythm_step_sequencer_unit #(
   parameter int MAX_STEPS = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rrss_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  logic [rrss_pkg::CsrDataWidth-1:0]    csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // click_level[15:0], reset_click[16], jump_step[32:17], zero fill[39:33]
   input  logic [rrss_pkg::ReqDataWidth-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // resultant_out[15:0], gen_a_out[31:16], gen_b_out[47:32], level_through[63:48],
   // cycle_pulse[64], step_number[76:65], zero fill[79:77]
   output logic [rrss_pkg::RspDataWidth-1:0]    rsp_tdata
);

   rrss_pkg::dp_cmd_type    cmd;
   rrss_pkg::dp_status_type status;

   rrss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rrss_datapath #(
      .MAX_STEPS (MAX_STEPS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

@@ design/rrss_ctrl.sv @@
// Sequencing controller: handshakes and the order of the three modulo passes.
module rrss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output rrss_pkg::dp_cmd_type  cmd,
   input  rrss_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_CNT,
      ST_RUN_CNT,
      ST_START_A,
      ST_RUN_A,
      ST_START_B,
      ST_RUN_B,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd          = '0;
      cmd.sel      = rrss_pkg::MOD_STEPS;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START_CNT;
            end
         end
         ST_START_CNT: begin
            cmd.start = 1'b1;
            cmd.sel   = rrss_pkg::MOD_STEPS;
            state_in  = ST_RUN_CNT;
         end
         ST_RUN_CNT: begin
            cmd.step = 1'b1;
            if (status.mod_done) state_in = ST_START_A;
         end
         ST_START_A: begin
            cmd.start    = 1'b1;
            cmd.sel      = rrss_pkg::MOD_PER_A;
            cmd.save_cnt = 1'b1;
            state_in     = ST_RUN_A;
         end
         ST_RUN_A: begin
            cmd.step = 1'b1;
            if (status.mod_done) state_in = ST_START_B;
         end
         ST_START_B: begin
            cmd.start  = 1'b1;
            cmd.sel    = rrss_pkg::MOD_PER_B;
            cmd.save_a = 1'b1;
            state_in   = ST_RUN_B;
         end
         ST_RUN_B: begin
            cmd.step = 1'b1;
            if (status.mod_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/rrss_datapath.sv @@
// Datapath: configuration, step counter, shared restoring modulo unit, result register.
module rrss_datapath #(
   parameter int MAX_STEPS = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [rrss_pkg::CsrAddrWidth-1:0]      csr_addr,
   input  logic [rrss_pkg::CsrDataWidth-1:0]      csr_wdata,
   input  logic [rrss_pkg::ReqDataWidth-1:0]      req_tdata,
   output logic [rrss_pkg::RspDataWidth-1:0]      rsp_tdata,
   input  rrss_pkg::dp_cmd_type                   cmd,
   output rrss_pkg::dp_status_type                status
);

   localparam logic [rrss_pkg::CntWidth-1:0] SatSteps =
      (MAX_STEPS > int'(rrss_pkg::CntMax)) ? rrss_pkg::CntMax
                                           : rrss_pkg::CntWidth'(MAX_STEPS);

   logic                               pattern_ff;
   logic [rrss_pkg::GenWidth-1:0]      gen_a_ff, gen_b_ff;
   logic [rrss_pkg::LevelWidth-1:0]    level_ff;
   logic                               rst_ff;
   logic [rrss_pkg::JumpWidth-1:0]     jump_ff;
   logic [rrss_pkg::CntWidth-1:0]      cnt_ff;
   logic [rrss_pkg::JumpWidth-1:0]     prev_jump_ff;
   logic [rrss_pkg::DvdWidth-1:0]      dvd_ff, dvd_in;
   logic [rrss_pkg::CntWidth-1:0]      div_ff, div_in;
   logic [rrss_pkg::CntWidth-1:0]      rem_ff;
   logic [rrss_pkg::IterWidth-1:0]     iter_ff;
   logic                               bit_a_ff;
   logic [rrss_pkg::RspDataWidth-1:0]  out_ff;

   logic [rrss_pkg::GenWidth-1:0]      per_a, per_b;
   logic [rrss_pkg::CntWidth-1:0]      prod, steps;
   logic                               positive, jump_new;
   logic [rrss_pkg::CntWidth:0]        cnt_inc;
   logic [rrss_pkg::CntWidth:0]        trial, diff;
   logic [rrss_pkg::CntWidth-1:0]      rem_next;
   logic                               ab, bb;
   logic [rrss_pkg::LevelWidth-1:0]    out_a, out_b, out_r;
   logic                               pulse;

   assign per_a    = (gen_a_ff == '0) ? rrss_pkg::GenWidth'(1) : gen_a_ff;
   assign per_b    = (gen_b_ff == '0) ? rrss_pkg::GenWidth'(1) : gen_b_ff;
   assign prod     = rrss_pkg::CntWidth'(per_a) * rrss_pkg::CntWidth'(per_b);
   assign steps    = !pattern_ff ? rrss_pkg::CntWidth'(1)
                   : (prod > SatSteps) ? SatSteps : prod;

   assign positive = (level_ff != '0) && !level_ff[rrss_pkg::LevelWidth-1];
   assign jump_new = (jump_ff != '0) && (jump_ff != prev_jump_ff);
   assign cnt_inc  = {1'b0, cnt_ff} + (rrss_pkg::CntWidth+1)'(positive);

   always_comb begin
      dvd_in = '0;
      div_in = steps;
      case (cmd.sel)
         rrss_pkg::MOD_STEPS: begin
            div_in = steps;
            if (jump_new)    dvd_in = jump_ff - rrss_pkg::JumpWidth'(1);
            else if (rst_ff) dvd_in = '0;
            else             dvd_in = rrss_pkg::DvdWidth'(cnt_inc);
         end
         rrss_pkg::MOD_PER_A: begin
            div_in = rrss_pkg::CntWidth'(per_a);
            dvd_in = rrss_pkg::DvdWidth'(rem_ff);
         end
         rrss_pkg::MOD_PER_B: begin
            div_in = rrss_pkg::CntWidth'(per_b);
            dvd_in = rrss_pkg::DvdWidth'(cnt_ff);
         end
         default: begin
            div_in = steps;
            dvd_in = '0;
         end
      endcase
   end

   assign trial    = {rem_ff, dvd_ff[rrss_pkg::DvdWidth-1]};
   assign diff     = trial - {1'b0, div_ff};
   assign rem_next = (trial >= {1'b0, div_ff}) ? diff[rrss_pkg::CntWidth-1:0]
                                               : trial[rrss_pkg::CntWidth-1:0];
   assign status.mod_done = cmd.step && (iter_ff == rrss_pkg::IterLast);

   assign ab    = pattern_ff && bit_a_ff;
   assign bb    = pattern_ff && (rem_ff == '0);
   assign out_a = ab ? level_ff : '0;
   assign out_b = bb ? level_ff : '0;
   assign out_r = (ab || bb) ? level_ff : '0;
   assign pulse = (cnt_ff == '0) && (level_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= 1'b0;
         gen_a_ff     <= '0;
         gen_b_ff     <= '0;
         cnt_ff       <= '0;
         prev_jump_ff <= '0;
         iter_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               rrss_pkg::CSR_PATTERN: pattern_ff <= csr_wdata[0];
               rrss_pkg::CSR_GEN_A:   gen_a_ff   <= csr_wdata[rrss_pkg::GenWidth-1:0];
               rrss_pkg::CSR_GEN_B:   gen_b_ff   <= csr_wdata[rrss_pkg::GenWidth-1:0];
               default: ;
            endcase
         end
         if (cmd.save_cnt) begin
            cnt_ff       <= rem_ff;
            prev_jump_ff <= jump_ff;
         end
         if (cmd.start)     iter_ff <= '0;
         else if (cmd.step) iter_ff <= iter_ff + rrss_pkg::IterWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         level_ff <= req_tdata[15:0];
         rst_ff   <= req_tdata[16];
         jump_ff  <= req_tdata[32:17];
      end
      if (cmd.start) begin
         dvd_ff <= dvd_in;
         div_ff <= div_in;
         rem_ff <= '0;
      end else if (cmd.step) begin
         dvd_ff <= {dvd_ff[rrss_pkg::DvdWidth-2:0], 1'b0};
         rem_ff <= rem_next;
      end
      if (cmd.save_a) bit_a_ff <= (rem_ff == '0);
      if (cmd.load_out) out_ff <= {3'd0, cnt_ff, pulse, level_ff, out_b, out_a, out_r};
   end

   assign rsp_tdata = out_ff;

endmodule

@@ design/rrss_checker.sv @@
// Port-level checks of the sequencer and their bind to the top level.
module rrss_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rrss_pkg::RspDataWidth-1:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken again right after a transaction");

   a_resultant_or: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] == (rsp_tdata[31:16] | rsp_tdata[47:32]))
      else $error("resultant is not the union of the generators");

   a_pulse_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tdata[76:65] == 12'd0 && rsp_tdata[63:48] != 16'd0)
      else $error("cycle pulse off step zero or with silent level");

endmodule

bind resultant_rhythm_step_sequencer_unit rrss_checker u_rrss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
